// File: src/fvcmc_pkg.sv
// ----------------------------------------------------------------------------
// fvcmc_pkg
// Shared types and constants for the FIFO vertex cache miss counter.
// ----------------------------------------------------------------------------
package fvcmc_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int VTX_W       = 16;
    localparam int CFG_W       = 6;
    localparam int CNT_W       = 32;
    localparam int PTR_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SIZE_NEED_W = $clog2(MAX_ENTRIES + 1);
    localparam int SIZE_W      = (SIZE_NEED_W > CFG_W) ? SIZE_NEED_W : CFG_W;

    localparam logic [CFG_W-1:0]  CACHE_SIZE_RESET = CFG_W'(16);
    localparam logic [CNT_W-1:0]  CNT_MAX          = {CNT_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_MAX         = SIZE_W'(MAX_ENTRIES);

    typedef struct packed {
        logic [VTX_W-1:0] vertex_index;
        logic             restart;
    } in_t;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] index_total;
    } out_t;

    typedef struct packed {
        logic             accept;
        logic             restart;
        logic             miss;
        logic [VTX_W-1:0] vertex;
    } cell_ctl_t;

endpackage

// File: src/fvcmc_cell.sv
// ----------------------------------------------------------------------------
// fvcmc_cell
// One cache entry: stored index, valid bit, compare, and hit chain link.
// ----------------------------------------------------------------------------
module fvcmc_cell
    import fvcmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      sel,
    input  logic      active,
    input  logic      hit_in,
    output logic      hit_out
);

    logic [VTX_W-1:0] index_reg;
    logic             valid_reg;
    logic             valid_next;
    logic             write;
    logic             match;

    assign match   = valid_reg && active && !ctl.restart && (index_reg == ctl.vertex);
    assign hit_out = hit_in | match;
    assign write   = ctl.accept && ctl.miss && sel;

    always_comb
    begin
        valid_next = valid_reg;
        if (write)
        begin
            valid_next = 1'b1;
        end
        else if (ctl.accept && ctl.restart)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            index_reg <= ctl.vertex;
        end
    end

endmodule

// File: src/fvcmc_out_skid.sv
// ----------------------------------------------------------------------------
// fvcmc_out_skid
// Output register with one skid entry; stalls input only when both are full.
// ----------------------------------------------------------------------------
module fvcmc_out_skid
    import fvcmc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  out_t din,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    out_t out_data_reg;
    out_t out_data_next;
    out_t skid_data_reg;
    out_t skid_data_next;
    logic out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : din;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// File: src/fifo_vertex_cache_miss_counter.sv
// ----------------------------------------------------------------------------
// fifo_vertex_cache_miss_counter
// FIFO post-transform vertex cache with saturating miss and index counters.
// ----------------------------------------------------------------------------
// Output: the result of each input transfer is registered in fvcmc_out_skid.
// Throughput: one index per cycle while in_stall is low; all cells compare
//   in parallel in the accepting cycle; a skid entry takes one result while output stalls.
// Reset: valid bits, insert pointer and counters clear at once; cache_size
//   returns to 16. No clearing pass.
// ----------------------------------------------------------------------------
module fifo_vertex_cache_miss_counter
    import fvcmc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data
);

    logic [CFG_W-1:0]  cache_size_reg;
    logic [SIZE_W-1:0] size_ext;
    logic [SIZE_W-1:0] eff_size;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic [PTR_W-1:0]  ptr_eff;
    logic [SIZE_W-1:0] ptr_inc;
    logic [CNT_W-1:0]  miss_count_reg;
    logic [CNT_W-1:0]  miss_count_next;
    logic [CNT_W-1:0]  index_count_reg;
    logic [CNT_W-1:0]  index_count_next;
    logic [CNT_W-1:0]  miss_base;
    logic [CNT_W-1:0]  index_base;
    logic              in_acc;
    logic              hit;
    logic [MAX_ENTRIES:0]   hit_chain;
    logic [MAX_ENTRIES-1:0] sel;
    logic [MAX_ENTRIES-1:0] active;
    cell_ctl_t         ctl;
    out_t              result;

    assign in_acc = in_valid && !in_stall;

    assign size_ext = SIZE_W'(cache_size_reg);

    always_comb
    begin
        eff_size = size_ext;
        if (size_ext == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (size_ext > SIZE_MAX)
        begin
            eff_size = SIZE_MAX;
        end
    end

    assign ptr_eff = (in_data.restart || (SIZE_W'(ptr_reg) >= eff_size)) ? '0 : ptr_reg;
    assign ptr_inc = SIZE_W'(ptr_eff) + SIZE_W'(1);

    assign ctl.accept  = in_acc;
    assign ctl.restart = in_data.restart;
    assign ctl.miss    = !hit;
    assign ctl.vertex  = in_data.vertex_index;

    assign hit_chain[0] = 1'b0;
    assign hit          = hit_chain[MAX_ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            assign sel[gi]    = (ptr_eff == PTR_W'(gi));
            assign active[gi] = (SIZE_W'(gi) < eff_size);
            fvcmc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .sel     (sel[gi]),
                .active  (active[gi]),
                .hit_in  (hit_chain[gi]),
                .hit_out (hit_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        miss_base  = in_data.restart ? '0 : miss_count_reg;
        index_base = in_data.restart ? '0 : index_count_reg;
        miss_count_next  = miss_base;
        index_count_next = (index_base == CNT_MAX) ? index_base : index_base + CNT_W'(1);
        ptr_next = in_data.restart ? '0 : ptr_reg;
        if (!hit)
        begin
            miss_count_next = (miss_base == CNT_MAX) ? miss_base : miss_base + CNT_W'(1);
            ptr_next = (ptr_inc >= eff_size) ? '0 : ptr_inc[PTR_W-1:0];
        end
    end

    assign result.hit         = hit;
    assign result.miss_total  = miss_count_next;
    assign result.index_total = index_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_size_reg  <= CACHE_SIZE_RESET;
            ptr_reg         <= '0;
            miss_count_reg  <= '0;
            index_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cache_size_reg <= cfg_wr_data;
            end
            if (in_acc)
            begin
                ptr_reg         <= ptr_next;
                miss_count_reg  <= miss_count_next;
                index_count_reg <= index_count_next;
            end
        end
    end

    fvcmc_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_acc),
        .din       (result),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output register");

    a_restart_counts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_data.restart |=> miss_count_reg == CNT_W'(1)
                                      && index_count_reg == CNT_W'(1))
        else $error("counters wrong after restart");

    a_hit_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && hit |=> $stable(miss_count_reg) && $stable(ptr_reg))
        else $error("hit changed miss count or insert pointer");

endmodule

// File: tb/fifo_vertex_cache_miss_counter_tb.sv
// ----------------------------------------------------------------------------
// fifo_vertex_cache_miss_counter_tb
// Self-checking bench for the FIFO vertex cache miss counter. A behavioral
// cache model predicts the hit flag and both running totals for every index
// transfer. The actual results are checked in order against that prediction.
// The bench first runs short directed checks: field extremes, clamped cache
// sizes, a size change mid-stream and a restart. It then sends random index
// buffers under a range of cache sizes, with random idle cycles on both
// channels.
// ----------------------------------------------------------------------------
module fifo_vertex_cache_miss_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fvcmc_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    in_t              in_data;
    logic             out_valid;
    logic             out_stall;
    out_t             out_data;

    // cache model
    logic [VTX_W-1:0]       cached_vtx [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cached_ok;
    int unsigned            fill_ptr;
    logic [CNT_W-1:0]       miss_run;
    logic [CNT_W-1:0]       seen_run;
    logic [CFG_W-1:0]       size_reg;

    out_t        lookup_q [$];
    int unsigned fail_count;
    int unsigned checked_count;
    int unsigned hit_count;
    int unsigned size_writes;
    bit          send_idle;
    bit          recv_idle;

    fifo_vertex_cache_miss_counter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned active_entries(input logic [CFG_W-1:0] sz);
        int unsigned n;
        n = 32'(sz);
        if (n < 1)
            n = 1;
        if (n > MAX_ENTRIES)
            n = MAX_ENTRIES;
        return n;
    endfunction

    function automatic void flush_cache_model();
        cached_ok = '0;
        fill_ptr  = 0;
        miss_run  = '0;
        seen_run  = '0;
    endfunction

    function automatic out_t lookup_vertex(input in_t item);
        out_t        res;
        int unsigned span;
        bit          found;
        span  = active_entries(size_reg);
        found = 1'b0;
        if (item.restart)
            flush_cache_model();
        for (int i = 0; i < span; i++)
        begin
            if (cached_ok[i] && cached_vtx[i] == item.vertex_index)
                found = 1'b1;
        end
        if (!found)
        begin
            if (fill_ptr >= span)
                fill_ptr = 0;
            cached_vtx[fill_ptr] = item.vertex_index;
            cached_ok[fill_ptr]  = 1'b1;
            fill_ptr++;
            if (fill_ptr >= span)
                fill_ptr = 0;
            if (miss_run != CNT_MAX)
                miss_run++;
        end
        if (seen_run != CNT_MAX)
            seen_run++;
        res.hit         = found;
        res.miss_total  = miss_run;
        res.index_total = seen_run;
        return res;
    endfunction

    task automatic send_vertex(input logic [VTX_W-1:0] vtx, input logic rs);
        int unsigned gap;
        in_t         item;
        item.vertex_index = vtx;
        item.restart      = rs;
        gap = send_idle ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        lookup_q.push_back(lookup_vertex(item));
    endtask

    // only while idle: all expected results drained first
    task automatic set_cache_size(input logic [CFG_W-1:0] sz);
        in_valid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sz;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        size_reg = sz;
        size_writes++;
    endtask

    task automatic test_default_size();
        send_vertex(16'h0000, 1'b1);
        send_vertex(16'hFFFF, 1'b0);
        send_vertex(16'h0000, 1'b0);
        send_vertex(16'hFFFF, 1'b0);
    endtask

    task automatic test_zero_size();
        set_cache_size(6'd0);
        send_vertex(16'h0005, 1'b1);
        send_vertex(16'h0005, 1'b0);
        send_vertex(16'h0006, 1'b0);
        send_vertex(16'h0005, 1'b0);
    endtask

    task automatic test_oversized();
        set_cache_size(6'd63);
        send_vertex(16'hAAAA, 1'b1);
        send_vertex(16'h5555, 1'b0);
        send_vertex(16'hAAAA, 1'b0);
    endtask

    task automatic test_size_change();
        set_cache_size(6'd2);
        send_vertex(16'h0001, 1'b1);
        send_vertex(16'h0002, 1'b0);
        send_vertex(16'h0003, 1'b0);
        send_vertex(16'h0001, 1'b0);
        set_cache_size(6'd4);
        send_vertex(16'h0002, 1'b0);
        send_vertex(16'h0001, 1'b0);
        set_cache_size(6'd1);
        send_vertex(16'h0003, 1'b0);
    endtask

    task automatic test_restart();
        send_vertex(16'h1234, 1'b0);
        send_vertex(16'h1234, 1'b0);
        send_vertex(16'h1234, 1'b1);
    endtask

    // index buffers drawn from a pool near the cache size, with some noise
    task automatic test_random_streams();
        logic [CFG_W-1:0] size_plan [10] = '{6'd16, 6'd1, 6'd32, 6'd0, 6'd63,
                                             6'd3, 6'd33, 6'd8, 6'd31, 6'd2};
        logic [CFG_W-1:0] sz;
        int unsigned      span;
        int unsigned      pool;
        int unsigned      base;
        int unsigned      buf_left;
        logic             rs;
        for (int ph = 0; ph < 12; ph++)
        begin
            sz = (ph < 10) ? size_plan[ph] : CFG_W'($urandom_range(0, 63));
            set_cache_size(sz);
            if (ph == 0)
                {send_idle, recv_idle} = 2'b00;
            else if (ph == 1)
                {send_idle, recv_idle} = 2'b11;
            else
                {send_idle, recv_idle} = 2'($urandom_range(0, 3));
            span     = active_entries(sz);
            pool     = span + $urandom_range(0, span);
            base     = $urandom_range(0, 65535);
            buf_left = 0;
            repeat (150)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_vertex(VTX_W'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
                else
                begin
                    rs = (buf_left == 0);
                    if (rs)
                        buf_left = $urandom_range(20, 200);
                    buf_left--;
                    send_vertex(VTX_W'(base + $urandom_range(0, pool - 1)), rs);
                end
            end
        end
    endtask

    initial
    begin : drive_out_stall
        int unsigned hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = recv_idle ? $urandom_range(0, 15) : 0;
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin : check_results
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (lookup_q.size() == 0)
            begin
                $error("unexpected transfer: hit=%0b miss_total=%0d index_total=%0d",
                       out_data.hit, out_data.miss_total, out_data.index_total);
                fail_count++;
            end
            else
            begin
                want = lookup_q.pop_front();
                checked_count++;
                if (out_data.hit === 1'b1)
                    hit_count++;
                if (out_data.hit !== want.hit)
                begin
                    $error("hit: expected %0b, got %0b", want.hit, out_data.hit);
                    fail_count++;
                end
                if (out_data.miss_total !== want.miss_total)
                begin
                    $error("miss_total: expected %0d, got %0d",
                           want.miss_total, out_data.miss_total);
                    fail_count++;
                end
                if (out_data.index_total !== want.index_total)
                begin
                    $error("index_total: expected %0d, got %0d",
                           want.index_total, out_data.index_total);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : run_tests
        int unsigned waited;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        send_idle   = 1'b1;
        recv_idle   = 1'b1;
        fail_count  = 0;
        size_writes = 0;
        size_reg    = CACHE_SIZE_RESET;
        flush_cache_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_size();
        test_zero_size();
        test_oversized();
        test_size_change();
        test_restart();
        test_random_streams();

        in_valid <= 1'b0;
        waited = 0;
        while (lookup_q.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (lookup_q.size() != 0)
        begin
            $error("%0d expected results never arrived", lookup_q.size());
            fail_count += lookup_q.size();
        end
        $display("Checked %0d index transfers (%0d hits) across %0d cache size writes,",
                 checked_count, hit_count, size_writes);
        $display("including zero, oversized and mid-stream size changes and restarts.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("Timeout: run did not complete");
        $display("Verification failed");
        $finish;
    end

endmodule
